// ----- sv/vscu_pkg.sv -----
`default_nettype none

package vscu_pkg;

  // request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_LINE  = 2'd1;
  localparam logic [1:0] REQ_BASE  = 2'd2;

  // word register indexes
  localparam logic [4:0] REG_CONTROL  = 5'd0;
  localparam logic [4:0] REG_H_BLANK  = 5'd1;
  localparam logic [4:0] REG_H_DISP   = 5'd2;
  localparam logic [4:0] REG_V_BLANK  = 5'd5;
  localparam logic [4:0] REG_V_DISP   = 5'd6;
  localparam logic [4:0] REG_INTERVAL = 5'd12;
  localparam logic [4:0] REG_TIMER_ACK = 5'd13;
  localparam logic [4:0] REG_SND_RESET = 5'd14;
  localparam logic [4:0] REG_IRQ_ACK   = 5'd15;
  localparam logic [4:0] REG_SND_ACK   = 5'd19;
  localparam logic [4:0] REG_FIELD_ACK = 5'd22;
  localparam logic [4:0] REG_VBL_ACK   = 5'd23;

  // interrupt level bits
  localparam int IRQ_VBL   = 0;
  localparam int IRQ_FIELD = 1;
  localparam int IRQ_TIMER = 2;

  localparam int LEN_W  = 13;
  localparam int LINE_W = 14;

  localparam logic [LEN_W-1:0]  LEN_SPAN       = 13'h1000;
  localparam logic [LEN_W-1:0]  RST_H_BLANK    = 13'd64;
  localparam logic [LEN_W-1:0]  RST_H_DISP     = 13'd320;
  localparam logic [LEN_W-1:0]  RST_V_BLANK    = 13'd39;
  localparam logic [LEN_W-1:0]  RST_V_DISP     = 13'd224;
  localparam logic [LEN_W-1:0]  RST_INTERVAL   = 13'd1;
  localparam logic [LINE_W-1:0] RST_LINE       = 14'd223;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  reg_index;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic              flip_screen;
    logic              dot_select;
    logic              vblank_irq;
    logic              field_irq;
    logic              timer_irq;
    logic              sound_ack;
    logic              sound_reset;
    logic [LEN_W-1:0]  h_display;
    logic [LINE_W-1:0] h_total;
    logic [LEN_W-1:0]  v_display;
    logic [LINE_W-1:0] v_total;
    logic [LINE_W-1:0] scan_line;
  } out_item_t;

  // stored length: 4096 minus the low 12 bits
  function automatic logic [LEN_W-1:0] len_from_data(input logic [15:0] d);
    return LEN_SPAN - {1'b0, d[11:0]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/video_system_control_unit_top.sv -----
// Flow: an accepted item waits in the input register, then moves into the output
//   register once that register is free or being read by the sink.
// Throughput: one item per cycle; the state update is a single compare/add step.
//   The input stalls only while both registers are full and the sink stalls.
// Reset: rst is synchronous, active high; clears both pipeline stages and loads
//   the CRTC, timer and interrupt state with their power-on values.
`default_nettype none

module video_system_control_unit_top (
  input  wire logic                clk,
  input  wire logic                rst,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vscu_pkg::in_item_t  in_data,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vscu_pkg::out_item_t      out_data,
  // configuration: swap of vblank and field lines
  input  wire logic                cfg_write,
  input  wire logic                cfg_data
);
  import vscu_pkg::*;

  // input register
  logic      s1_valid;
  in_item_t  s1_item;
  // the item in s1 moves into the output register this cycle
  logic      advance;
  out_item_t result;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  // back-pressure only when both stages are full and the sink is stalling
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  // state lives in the core; it commits only when the item moves on
  vscu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (advance),
    .item      (s1_item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // stall towards the source only when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held result");

  // an item in s1 must reach the output register once the sink frees it
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item lost");

  // a held result with a full input register keeps both stages full
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> (s1_valid && out_valid))
    else $error("pipeline emptied while stalled");

endmodule

`default_nettype wire

// ----- sv/vscu_core.sv -----
`default_nettype none

module vscu_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                cfg_data,
  input  wire logic                step,
  input  wire vscu_pkg::in_item_t  item,
  output vscu_pkg::out_item_t      result
);
  import vscu_pkg::*;

  logic              swap;
  logic              dot_bit, dot_bit_next;
  logic              flip_bit, flip_bit_next;
  logic [LEN_W-1:0]  h_blank, h_blank_next;
  logic [LEN_W-1:0]  h_disp, h_disp_next;
  logic [LEN_W-1:0]  v_blank, v_blank_next;
  logic [LEN_W-1:0]  v_disp, v_disp_next;
  logic              timer_en, timer_en_next;
  logic [LEN_W-1:0]  interval, interval_next;
  logic [LEN_W-1:0]  count, count_next;
  logic [LINE_W-1:0] line, line_next;
  logic              odd, odd_next;
  logic [2:0]        irq, irq_next;
  logic [1:0]        snd, snd_next;

  logic              reload;
  logic [LINE_W-1:0] v_total_cur, v_total_next, line_inc;
  logic [LEN_W-1:0]  len;

  assign v_total_cur  = {1'b0, v_blank} + {1'b0, v_disp};
  assign v_total_next = {1'b0, v_blank_next} + {1'b0, v_disp_next};
  assign len          = len_from_data(item.write_data);
  assign line_inc     = line + 14'd1;

  always_comb begin
    dot_bit_next  = dot_bit;
    flip_bit_next = flip_bit;
    h_blank_next  = h_blank;
    h_disp_next   = h_disp;
    v_blank_next  = v_blank;
    v_disp_next   = v_disp;
    timer_en_next = timer_en;
    interval_next = interval;
    count_next    = count;
    odd_next      = odd;
    irq_next      = irq;
    snd_next      = snd;
    reload        = 1'b0;
    line_next     = line;

    unique case (item.req_type)
      REQ_WRITE: begin
        unique case (item.reg_index)
          REG_CONTROL: begin
            if (item.write_data[0] != dot_bit) begin
              dot_bit_next = item.write_data[0];
              reload       = 1'b1;
            end
            flip_bit_next = item.write_data[1];
            timer_en_next = item.write_data[3];
            count_next    = interval;
            if (!item.write_data[3]) irq_next[IRQ_TIMER] = 1'b0;
          end
          REG_H_BLANK: begin
            h_blank_next = len;
            reload       = 1'b1;
          end
          REG_H_DISP: begin
            h_disp_next = len;
            reload      = 1'b1;
          end
          REG_V_BLANK: begin
            v_blank_next = len;
            reload       = 1'b1;
          end
          REG_V_DISP: begin
            v_disp_next = len;
            reload      = 1'b1;
          end
          REG_INTERVAL: begin
            interval_next = len;
            count_next    = len;
            if (!timer_en) irq_next[IRQ_TIMER] = 1'b0;
          end
          REG_TIMER_ACK: irq_next[IRQ_TIMER] = 1'b0;
          REG_SND_RESET: snd_next[1] = item.write_data[0];
          REG_IRQ_ACK: begin
            irq_next[IRQ_VBL]   = 1'b0;
            irq_next[IRQ_FIELD] = 1'b0;
          end
          REG_SND_ACK:   snd_next[0] = 1'b1;
          REG_FIELD_ACK: irq_next[IRQ_FIELD] = 1'b0;
          REG_VBL_ACK:   irq_next[IRQ_VBL] = 1'b0;
          default: ;
        endcase
      end
      REQ_LINE: begin
        if (line == {1'b0, v_disp}) begin
          if (swap) irq_next[IRQ_FIELD] = 1'b1;
          else      irq_next[IRQ_VBL]   = 1'b1;
          odd_next = ~odd;
        end
        if (line == '0 && odd_next) begin
          if (swap) irq_next[IRQ_VBL]   = 1'b1;
          else      irq_next[IRQ_FIELD] = 1'b1;
        end
        // counter never exceeds the total, so one subtract wraps it
        line_next = (line_inc >= v_total_cur) ? line_inc - v_total_cur : line_inc;
      end
      REQ_BASE: begin
        if (timer_en) begin
          if (count <= 13'd1) begin
            irq_next[IRQ_TIMER] = 1'b1;
            count_next          = interval;
          end else begin
            count_next = count - 13'd1;
          end
        end
      end
      default: ;
    endcase

    if (reload) line_next = v_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swap <= 1'b0;
    end else if (cfg_write) begin
      swap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_bit  <= 1'b0;
      flip_bit <= 1'b0;
      h_blank  <= RST_H_BLANK;
      h_disp   <= RST_H_DISP;
      v_blank  <= RST_V_BLANK;
      v_disp   <= RST_V_DISP;
      timer_en <= 1'b0;
      interval <= RST_INTERVAL;
      count    <= RST_INTERVAL;
      line     <= RST_LINE;
      odd      <= 1'b0;
      irq      <= '0;
      snd      <= '0;
    end else if (step) begin
      dot_bit  <= dot_bit_next;
      flip_bit <= flip_bit_next;
      h_blank  <= h_blank_next;
      h_disp   <= h_disp_next;
      v_blank  <= v_blank_next;
      v_disp   <= v_disp_next;
      timer_en <= timer_en_next;
      interval <= interval_next;
      count    <= count_next;
      line     <= line_next;
      odd      <= odd_next;
      irq      <= irq_next;
      snd      <= snd_next;
    end
  end

  always_comb begin
    result.flip_screen = flip_bit_next;
    result.dot_select  = dot_bit_next;
    result.vblank_irq  = irq_next[IRQ_VBL];
    result.field_irq   = irq_next[IRQ_FIELD];
    result.timer_irq   = irq_next[IRQ_TIMER];
    result.sound_ack   = snd_next[0];
    result.sound_reset = snd_next[1];
    result.h_display   = h_disp_next;
    result.h_total     = {1'b0, h_blank_next} + {1'b0, h_disp_next};
    result.v_display   = v_disp_next;
    result.v_total     = v_total_next;
    result.scan_line   = line_next;
  end

  // the single-subtract wrap relies on this
  a_line_in_range: assert property (@(posedge clk) disable iff (rst)
    line <= v_total_cur)
    else $error("scanline counter beyond vertical total");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= LEN_SPAN)
    else $error("timer count out of range");

  a_lens_nonzero: assert property (@(posedge clk) disable iff (rst)
    v_blank != '0 && v_disp != '0 && interval != '0)
    else $error("stored length is zero");

endmodule

`default_nettype wire

// ----- bench/video_system_control_unit_top_tb.sv -----
module video_system_control_unit_top_tb;
  import vscu_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] REQ_NONE     = 2'd3;   // unknown request kind, must be a no-op
  localparam logic [4:0] REG_PORCH_H0 = 5'd3;
  localparam logic [4:0] REG_PORCH_V1 = 5'd8;
  localparam logic [4:0] REG_WATCHDOG = 5'd20;
  localparam logic [4:0] REG_LAST     = 5'd31;

  // control register bits and sound line bits
  localparam int CTRL_DOT      = 0;
  localparam int CTRL_FLIP     = 1;
  localparam int CTRL_TIMER_EN = 3;
  localparam int SND_ACK_BIT   = 0;
  localparam int SND_RESET_BIT = 1;

  localparam int IDLE_MAX        = 17;
  localparam int HOLD_CYCLES     = 300;     // long receiver hold-off, fills the pipe
  localparam int SETTLE_CYCLES   = 4;       // covers the pipeline latency, with margin
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_SEGMENTS = 8;
  localparam int SEGMENT_ITEMS   = 145;
  localparam int REPORT_LIMIT    = 40;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_write;
  logic      cfg_data;

  video_system_control_unit_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the unit's state, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic              p_swap;
  logic              p_dot;
  logic              p_flip;
  logic              p_tmr_en;
  logic              p_odd;
  logic [LEN_W-1:0]  p_hblank;
  logic [LEN_W-1:0]  p_hdisp;
  logic [LEN_W-1:0]  p_vblank;
  logic [LEN_W-1:0]  p_vdisp;
  logic [LEN_W-1:0]  p_tmr_ival;
  logic [LEN_W-1:0]  p_tmr_cnt;
  logic [LINE_W-1:0] p_line;
  logic [2:0]        p_irq;
  logic [1:0]        p_snd;

  out_item_t status_due[$];   // status words still owed by the unit, oldest first

  // control knobs for the sender and receiver processes
  bit idle_src;
  bit idle_snk;
  bit hold_request;

  // bookkeeping
  int mismatches;
  int items_sent;
  int status_checked;
  int vblank_events;
  int field_events;
  int timer_events;
  int holds_done;
  int swap_writes;
  int held_off_cycles;
  int cycle_count;

  function automatic logic [LEN_W-1:0] stored_len(input logic [15:0] d);
    logic [LEN_W-1:0] low;
    low = {1'b0, d[11:0]};
    return 13'd4096 - low;
  endfunction

  function automatic logic [LINE_W-1:0] frame_lines();
    return {1'b0, p_vblank} + {1'b0, p_vdisp};
  endfunction

  function automatic void restart_timer();
    p_tmr_cnt = p_tmr_ival;
    if (!p_tmr_en) p_irq[IRQ_TIMER] = 1'b0;
  endfunction

  function automatic void reset_prediction();
    p_swap     = 1'b0;
    p_dot      = 1'b0;
    p_flip     = 1'b0;
    p_tmr_en   = 1'b0;
    p_odd      = 1'b0;
    p_hblank   = RST_H_BLANK;
    p_hdisp    = RST_H_DISP;
    p_vblank   = RST_V_BLANK;
    p_vdisp    = RST_V_DISP;
    p_tmr_ival = RST_INTERVAL;
    p_tmr_cnt  = RST_INTERVAL;
    p_line     = RST_LINE;
    p_irq      = '0;
    p_snd      = '0;
  endfunction

  function automatic void apply_write(input logic [4:0] idx, input logic [15:0] d);
    case (idx)
      REG_CONTROL: begin
        // only a change of dot clock restarts the frame
        if (d[CTRL_DOT] != p_dot) begin
          p_dot  = d[CTRL_DOT];
          p_line = frame_lines();
        end
        p_flip   = d[CTRL_FLIP];
        p_tmr_en = d[CTRL_TIMER_EN];
        restart_timer();
      end
      REG_H_BLANK: begin
        p_hblank = stored_len(d);
        p_line   = frame_lines();
      end
      REG_H_DISP: begin
        p_hdisp = stored_len(d);
        p_line  = frame_lines();
      end
      REG_V_BLANK: begin
        p_vblank = stored_len(d);
        p_line   = frame_lines();
      end
      REG_V_DISP: begin
        p_vdisp = stored_len(d);
        p_line  = frame_lines();
      end
      REG_INTERVAL: begin
        p_tmr_ival = stored_len(d);
        restart_timer();
      end
      REG_TIMER_ACK: p_irq[IRQ_TIMER] = 1'b0;
      REG_SND_RESET: p_snd[SND_RESET_BIT] = d[0];
      REG_IRQ_ACK: begin
        p_irq[IRQ_VBL]   = 1'b0;
        p_irq[IRQ_FIELD] = 1'b0;
      end
      REG_SND_ACK:   p_snd[SND_ACK_BIT] = 1'b1;
      REG_FIELD_ACK: p_irq[IRQ_FIELD] = 1'b0;
      REG_VBL_ACK:   p_irq[IRQ_VBL] = 1'b0;
      default: ;
    endcase
  endfunction

  // Advance the shadow state by one request and return the status word it leaves.
  function automatic out_item_t advance_unit(input in_item_t it);
    out_item_t   r;
    int unsigned cur;
    int unsigned nxt;
    case (it.req_type)
      REQ_WRITE: apply_write(it.reg_index, it.write_data);
      REQ_LINE: begin
        cur = 32'(p_line);
        if (cur == p_vdisp) begin
          p_irq[p_swap ? IRQ_FIELD : IRQ_VBL] = 1'b1;
          p_odd = ~p_odd;
          vblank_events++;
        end
        if (cur == 0 && p_odd) begin
          p_irq[p_swap ? IRQ_VBL : IRQ_FIELD] = 1'b1;
          field_events++;
        end
        nxt    = (cur + 1) % 32'(frame_lines());
        p_line = LINE_W'(nxt);
      end
      REQ_BASE: begin
        if (p_tmr_en) begin
          if (p_tmr_cnt <= 1) begin
            p_irq[IRQ_TIMER] = 1'b1;
            p_tmr_cnt = p_tmr_ival;
            timer_events++;
          end else begin
            p_tmr_cnt = p_tmr_cnt - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.flip_screen = p_flip;
    r.dot_select  = p_dot;
    r.vblank_irq  = p_irq[IRQ_VBL];
    r.field_irq   = p_irq[IRQ_FIELD];
    r.timer_irq   = p_irq[IRQ_TIMER];
    r.sound_ack   = p_snd[SND_ACK_BIT];
    r.sound_reset = p_snd[SND_RESET_BIT];
    r.h_display   = p_hdisp;
    r.h_total     = {1'b0, p_hblank} + {1'b0, p_hdisp};
    r.v_display   = p_vdisp;
    r.v_total     = frame_lines();
    r.scan_line   = p_line;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle count and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_stall) held_off_cycles <= held_off_cycles + 1;
  end

  // a hung handshake ends up here
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and the status word check
  // ---------------------------------------------------------------------------
  function automatic int idle_draw(input bit enabled);
    return enabled ? int'($urandom_range(0, IDLE_MAX)) : 0;
  endfunction

  // Receiver: per status word a random hold-off, plus the one long hold when asked.
  // Only one assignment to out_stall per time step.
  initial begin : result_sink
    int wait_n;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      wait_n = idle_draw(idle_snk);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic check_field(input string nm, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, nm, want_v, got_v);
    end
  endtask

  // Each transferred status word is checked against the oldest one owed.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t unexpected status word, expected none, got %h", $time, out_data);
      end else begin
        want = status_due.pop_front();
        check_field("flip_screen", 16'(want.flip_screen), 16'(out_data.flip_screen));
        check_field("dot_select",  16'(want.dot_select),  16'(out_data.dot_select));
        check_field("vblank_irq",  16'(want.vblank_irq),  16'(out_data.vblank_irq));
        check_field("field_irq",   16'(want.field_irq),   16'(out_data.field_irq));
        check_field("timer_irq",   16'(want.timer_irq),   16'(out_data.timer_irq));
        check_field("sound_ack",   16'(want.sound_ack),   16'(out_data.sound_ack));
        check_field("sound_reset", 16'(want.sound_reset), 16'(out_data.sound_reset));
        check_field("h_display",   16'(want.h_display),   16'(out_data.h_display));
        check_field("h_total",     16'(want.h_total),     16'(out_data.h_total));
        check_field("v_display",   16'(want.v_display),   16'(out_data.v_display));
        check_field("v_total",     16'(want.v_total),     16'(out_data.v_total));
        check_field("scan_line",   16'(want.scan_line),   16'(out_data.scan_line));
        status_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic in_item_t request(input logic [1:0] kind, input logic [4:0] idx,
                                       input logic [15:0] d);
    in_item_t it;
    it.req_type   = kind;
    it.reg_index  = idx;
    it.write_data = d;
    return it;
  endfunction

  // One transfer. valid stays high into the next call when its gap is zero,
  // so callers either send again in the same step or call settle().
  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_draw(idle_src);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    status_due.push_back(advance_unit(it));
    items_sent++;
  endtask

  task automatic bus_write(input logic [4:0] idx, input logic [15:0] d);
    send_item(request(REQ_WRITE, idx, d));
  endtask

  task automatic line_tick();
    send_item(request(REQ_LINE, '0, '0));
  endtask

  task automatic base_tick();
    send_item(request(REQ_BASE, '0, '0));
  endtask

  // drop valid, let every owed status word come back, then give the pipe a moment
  task automatic settle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // swap setting is only touched with the unit idle
  task automatic set_swap(input logic v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    p_swap = v;
    swap_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Unknown request kind, then two ticks from the power-on counter: the second
  // lands on the display end and raises vblank.
  task automatic test_reset_defaults();
    send_item(request(REQ_NONE, REG_LAST, 16'hFFFF));
    line_tick();
    line_tick();
    settle();
  endtask

  // Sound lines, vblank ack and writes that must change nothing.
  task automatic test_acks_and_sound();
    bus_write(REG_SND_ACK, 16'h0000);
    bus_write(REG_SND_RESET, 16'h0001);
    bus_write(REG_SND_RESET, 16'hFFFE);
    bus_write(REG_VBL_ACK, 16'hFFFF);
    bus_write(REG_PORCH_H0, 16'hFFFF);
    bus_write(REG_PORCH_V1, 16'h0000);
    bus_write(REG_WATCHDOG, 16'hFFFF);
    settle();
  endtask

  // Shortest frame (one blank, one display line): reload to the total, wrap to 1,
  // two vblanks so the odd frame brings the field line. Then the longest lengths.
  task automatic test_crtc_frame();
    bus_write(REG_V_BLANK, 16'hFFFF);
    bus_write(REG_V_DISP, 16'h0FFF);
    repeat (5) line_tick();
    bus_write(REG_FIELD_ACK, 16'h0000);
    bus_write(REG_IRQ_ACK, 16'hFFFF);
    bus_write(REG_H_BLANK, 16'h0000);
    bus_write(REG_H_DISP, 16'hF000);
    bus_write(REG_V_BLANK, 16'h0000);
    bus_write(REG_V_DISP, 16'hF000);
    line_tick();
    settle();
  endtask

  // Timer every two base ticks; disabling it drops the line and later ticks are
  // ignored. The control writes also flip the dot clock, which reloads the frame.
  task automatic test_timer();
    bus_write(REG_CONTROL, 16'h000B);
    bus_write(REG_INTERVAL, 16'hFFFE);
    base_tick();
    base_tick();
    bus_write(REG_CONTROL, 16'h0000);
    base_tick();
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // data whose stored length falls in 1..max_len, upper bits random
  function automatic logic [15:0] len_data(input int max_len);
    logic [15:0] d;
    d = 16'($urandom);
    d[11:0] = 12'(4096 - $urandom_range(1, max_len));
    return d;
  endfunction

  function automatic logic [15:0] short_or_full_len();
    return ($urandom_range(0, 15) == 0) ? len_data(4096) : len_data(24);
  endfunction

  // Requests inside a frame: no CRTC reloads except by the rare stray index,
  // control writes keep the dot clock.
  function automatic in_item_t framed_request();
    in_item_t    it;
    logic [15:0] d;
    int          pick;
    it   = request(REQ_LINE, 5'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick >= 50 && pick < 75) begin
      it.req_type = REQ_BASE;
    end else if (pick >= 75) begin
      it.req_type = REQ_WRITE;
      case ($urandom_range(0, 9))
        0: begin
          d = 16'($urandom);
          d[CTRL_DOT] = p_dot;
          it.reg_index  = REG_CONTROL;
          it.write_data = d;
        end
        1: begin
          it.reg_index  = REG_INTERVAL;
          it.write_data = len_data(8);
        end
        2: it.reg_index = REG_TIMER_ACK;
        3: it.reg_index = REG_SND_RESET;
        4: it.reg_index = REG_IRQ_ACK;
        5: it.reg_index = REG_SND_ACK;
        6: it.reg_index = REG_FIELD_ACK;
        7: it.reg_index = REG_VBL_ACK;
        8: it.reg_index = REG_WATCHDOG;
        default: it.reg_index = 5'($urandom_range(0, 31));
      endcase
    end
    return it;
  endfunction

  function automatic in_item_t noise_request();
    return request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 16'($urandom));
  endfunction

  // Optional frame and timer set-up, a run of in-frame traffic, sometimes noise.
  task automatic random_burst(output int n_sent);
    logic [15:0] d;
    int          n;
    n_sent = 0;
    if ($urandom_range(0, 3) == 0) begin
      bus_write(REG_V_BLANK, short_or_full_len());
      bus_write(REG_V_DISP, short_or_full_len());
      n_sent += 2;
    end
    if ($urandom_range(0, 3) == 0) begin
      d = 16'($urandom);
      d[CTRL_TIMER_EN] = ($urandom_range(0, 3) != 0);
      bus_write(REG_CONTROL, d);
      bus_write(REG_INTERVAL, ($urandom_range(0, 7) == 0) ? len_data(4096) : len_data(6));
      n_sent += 2;
    end
    n = $urandom_range(8, 48);
    repeat (n) send_item(framed_request());
    n_sent += n;
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) send_item(noise_request());
      n_sent += n;
    end
  endtask

  // Segments cycle through no idling, sender idling, receiver idling and both.
  // The swap setting changes between segments; one segment gets the long hold
  // with the sender pushing flat out, so in_stall must come up.
  task automatic test_random_traffic();
    int seg;
    int got;
    int n;
    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      if (seg == 2 || seg == 6) set_swap(1'b1);
      else if (seg == 4) set_swap(1'b0);
      idle_src = seg[0];
      idle_snk = seg[1];
      if (seg == 5) begin
        idle_src     = 1'b0;
        hold_request = 1'b1;
      end
      got = 0;
      while (got < SEGMENT_ITEMS) begin
        random_burst(n);
        got += n;
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_data  <= 1'b0;
    idle_src     = 1'b0;
    idle_snk     = 1'b0;
    hold_request = 1'b0;
    reset_prediction();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_swap(1'b0);
    test_reset_defaults();
    idle_src = 1'b1;
    idle_snk = 1'b1;
    test_acks_and_sound();
    test_crtc_frame();
    test_timer();
    test_random_traffic();
    set_swap(1'b0);

    // any late or stray status word would show up in this window
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (status_due.size() != 0) begin
      mismatches++;
      $display("%0t %0d status words never arrived", $time, status_due.size());
    end

    $display("Sent %0d requests, checked %0d status words in %0d cycles; swap set %0d times.",
             items_sent, status_checked, cycle_count, swap_writes);
    $display("Saw %0d vblank, %0d field, %0d timer events; %0d long hold(s), %0d cycles held off.",
             vblank_events, field_events, timer_events, holds_done, held_off_cycles);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
